// File: rtl/core/sre_pkg.sv
package sre_pkg;

    localparam int WORD_BITS   = 32;
    localparam int CODE_BITS   = 64;
    localparam int STREAM_BITS = WORD_BITS + CODE_BITS;
    localparam int FILL_W      = 7;
    localparam int EXP_W       = 5;
    localparam int K_W         = 4;
    localparam int MAG_W       = 31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_CODE,
        ST_MERGE,
        ST_EMIT
    } sre_state_t;

    typedef struct packed {
        logic load;
        logic len_en;
        logic code_en;
        logic merge_en;
        logic pop;
    } sre_cmd_t;

    typedef struct packed {
        logic emit_pending;
        logic word_last;
    } sre_status_t;

    // Index of the highest set bit of the magnitude, zero when it is 0 or 1.
    function automatic logic [EXP_W-1:0] sre_msb_index(input logic [MAG_W-1:0] mag);
        logic [EXP_W-1:0] idx;
        idx = '0;
        for (int i = 1; i < MAG_W; i++) begin
            if (mag[i]) begin
                idx = EXP_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: rtl/core/sre_ctrl.sv
module sre_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  logic                load_flush,
    input  sre_pkg::sre_status_t status,
    output sre_pkg::sre_cmd_t    cmd
);
    import sre_pkg::*;

    sre_state_t state_reg;
    sre_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = load_flush ? ST_EMIT : ST_LEN;
                end
            end
            ST_LEN:   state_next = ST_CODE;
            ST_CODE:  state_next = ST_MERGE;
            ST_MERGE: state_next = ST_EMIT;
            ST_EMIT: begin
                if (!status.emit_pending) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        m_valid      = (state_reg == ST_EMIT) && status.emit_pending;
        cmd.load     = (state_reg == ST_IDLE) && s_valid;
        cmd.len_en   = (state_reg == ST_LEN);
        cmd.code_en  = (state_reg == ST_CODE);
        cmd.merge_en = (state_reg == ST_MERGE);
        cmd.pop      = m_valid && m_ready;
    end

endmodule

// File: rtl/core/sre_datapath.sv
module sre_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  sre_pkg::sre_cmd_t    cmd,
    input  logic                s_cmd,
    input  logic signed [31:0]  s_value,
    input  logic [3:0]          s_rice_param,
    output sre_pkg::sre_status_t status,
    output logic [31:0]         m_packed_word,
    output logic                m_last
);
    import sre_pkg::*;

    logic                   flush_reg;
    logic                   neg_reg;
    logic [MAG_W-1:0]       mag_reg;
    logic [K_W-1:0]         k_reg;
    logic [EXP_W-1:0]       exp_reg;
    logic [CODE_BITS-1:0]   code_reg;
    logic [FILL_W-1:0]      len_reg;
    logic [FILL_W-1:0]      shamt_reg;
    logic [STREAM_BITS-1:0] stream_reg;
    logic [FILL_W-1:0]      fill_reg;

    logic [EXP_W-1:0]       tail_len;
    logic [EXP_W-1:0]       zeros;
    logic [FILL_W-1:0]      code_len;
    logic [15:0]            exp_low;
    logic [16:0]            marker;
    logic [CODE_BITS-1:0]   mag_bits;
    logic [CODE_BITS-1:0]   body;
    logic [CODE_BITS-1:0]   code_next;
    logic [FILL_W:0]        shamt_wide;

    always_comb begin
        tail_len   = (exp_reg == '0) ? EXP_W'(1) : exp_reg;
        zeros      = exp_reg >> k_reg;
        code_len   = FILL_W'(2) + FILL_W'(zeros) + FILL_W'(k_reg) + FILL_W'(tail_len);
        exp_low    = 16'(exp_reg) & ((16'd1 << k_reg) - 16'd1);
        marker     = 17'(exp_low) | (17'd1 << k_reg);
        mag_bits   = CODE_BITS'(mag_reg) & ((CODE_BITS'(1) << tail_len) - CODE_BITS'(1));
        body       = (CODE_BITS'(marker) << tail_len) | mag_bits;
        code_next  = body | (CODE_BITS'(neg_reg) << (code_len - FILL_W'(1)));
        shamt_wide = (FILL_W+1)'(STREAM_BITS) - (FILL_W+1)'(fill_reg)
                   - (FILL_W+1)'(code_len);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flush_reg  <= 1'b0;
            stream_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (cmd.load) begin
                flush_reg <= s_cmd;
            end
            if (cmd.merge_en) begin
                stream_reg <= stream_reg | (STREAM_BITS'(code_reg) << shamt_reg);
                fill_reg   <= fill_reg + len_reg;
            end else if (cmd.pop) begin
                stream_reg <= stream_reg << WORD_BITS;
                fill_reg   <= flush_reg ? '0 : fill_reg - FILL_W'(WORD_BITS);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            neg_reg <= s_value[31];
            mag_reg <= s_value[31] ? ~s_value[MAG_W-1:0] : s_value[MAG_W-1:0];
            k_reg   <= s_rice_param;
        end
        if (cmd.len_en) begin
            exp_reg <= sre_msb_index(mag_reg);
        end
        if (cmd.code_en) begin
            code_reg  <= code_next;
            len_reg   <= code_len;
            shamt_reg <= shamt_wide[FILL_W-1:0];
        end
    end

    always_comb begin
        status.emit_pending = (fill_reg >= FILL_W'(WORD_BITS))
                            || (flush_reg && (fill_reg != '0));
        status.word_last    = flush_reg || (fill_reg < FILL_W'(2 * WORD_BITS));
        m_packed_word       = stream_reg[STREAM_BITS-1 -: WORD_BITS];
        m_last              = status.word_last;
    end

endmodule

// File: rtl/core/signed_rice_exponent_encoder_top.sv
// An encode transfer steps through accept, length search, code build and merge, then
// offers each output word it completes (0 to 2 words), and returns to idle before the
// next input is taken.
// A flush goes straight from idle to emit and offers 0 or 1 words; stalls hold emit.
// The first word of an encode is offered in the emit state, after the length, code and merge states.
// Reset is synchronous and active low; it empties the bit buffer and returns to idle.
module signed_rice_exponent_encoder_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic signed [31:0] s_value,
    input  logic [3:0]         s_rice_param,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_packed_word,
    output logic               m_last
);
    import sre_pkg::*;

    sre_cmd_t    cmd;
    sre_status_t status;

    sre_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .load_flush (s_cmd),
        .status     (status),
        .cmd        (cmd)
    );

    sre_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_cmd         (s_cmd),
        .s_value       (s_value),
        .s_rice_param  (s_rice_param),
        .status        (status),
        .m_packed_word (m_packed_word),
        .m_last        (m_last)
    );

endmodule

// File: rtl/core/sre_checker.sv
module sre_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_packed_word,
    input logic        m_last
);

    // A stalled output word must hold.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_packed_word) && $stable(m_last))
        else $error("output word changed while stalled");

    // Input is never taken while a word is offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while output valid");

    // An input transfer is followed by a busy cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a transfer");

    // Nothing follows the final word of an item at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> !m_valid)
        else $error("output valid right after final word");

endmodule

bind signed_rice_exponent_encoder_top sre_checker u_sre_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_packed_word (m_packed_word),
    .m_last        (m_last)
);
